// File: hdl/asd_pkg.sv
// Shared types and constants for the audio silence span detector.
// No dependencies; imported by every module of the block.
`default_nettype none

package asd_pkg;

	// Full scale in unsigned Q1.31
	localparam logic [31:0] FULL_SCALE    = 32'h8000_0000;
	localparam logic [31:0] THRESH_RESET  = 32'd2147484;
	localparam int          OUT_CNT_BITS  = 40;

	// Input transaction kinds carried on tuser
	typedef enum logic [1:0] {
		ACT_SAMPLE = 2'd0,
		ACT_REPORT = 2'd1,
		ACT_ABORT  = 2'd2
	} action_t;

	// Sample formats; codes above FMT_U8 are unreadable
	typedef enum logic [2:0] {
		FMT_F32 = 3'd0,
		FMT_I16 = 3'd1,
		FMT_I32 = 3'd2,
		FMT_U8  = 3'd3
	} format_t;

	typedef enum logic [1:0] {
		ST_CONTENT = 2'd0,
		ST_SILENT  = 2'd1,
		ST_BADFMT  = 2'd2,
		ST_EMPTY   = 2'd3
	} status_t;

	// Configuration register indexes
	localparam logic REG_THRESHOLD = 1'b0;
	localparam logic REG_FORMAT    = 1'b1;

	// One end-of-stream report
	typedef struct packed {
		logic [OUT_CNT_BITS-1:0] trailing;
		logic [OUT_CNT_BITS-1:0] leading;
		logic [OUT_CNT_BITS-1:0] total;
		status_t                 status;
	} result_t;

	// Magnitude of one sample and whether the format was readable
	typedef struct packed {
		logic        fmt_ok;
		logic [31:0] mag;
	} mag_t;

endpackage

`default_nettype wire

// File: hdl/asd_cfg.sv
// APB-style register file: loudness threshold and sample format.
// Depends on asd_pkg for register indexes and reset values.
`default_nettype none

module asd_cfg
	import asd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	output logic [31:0]      threshold,
	output logic [2:0]       sample_format
);

	logic [31:0] thresh_q;
	logic [2:0]  fmt_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	// Write on the access phase; register index is the word address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RESET;
			fmt_q    <= FMT_F32;
		end else if (wr_en) begin
			if (paddr[2] == REG_THRESHOLD) begin
				thresh_q <= pwdata;
			end else begin
				fmt_q <= pwdata[2:0];
			end
		end
	end

	// Read back
	assign prdata        = (paddr[2] == REG_FORMAT) ? {29'd0, fmt_q} : thresh_q;
	assign threshold     = thresh_q;
	assign sample_format = fmt_q;

endmodule

`default_nettype wire

// File: hdl/asd_mag.sv
// Sample-to-magnitude conversion into unsigned Q1.31 for all four formats.
// Depends on asd_pkg for format codes and the magnitude struct.
`default_nettype none

module asd_mag
	import asd_pkg::*;
(
	input  wire logic [31:0] sample_bits,
	input  wire logic [2:0]  sample_format,
	output mag_t             mag
);

	logic [31:0] f32_mag;

	// Float: saturate at 1.0, NaN and subnormals give zero
	always_comb begin
		logic [7:0]  e;
		logic [22:0] m;
		logic [31:0] man;
		logic [7:0]  lsh;
		logic [7:0]  rsh;
		e   = sample_bits[30:23];
		m   = sample_bits[22:0];
		man = {8'd0, 1'b1, m};
		lsh = 8'(e - 8'd119);
		rsh = 8'(8'd119 - e);
		if (e == 8'hFF) begin
			f32_mag = (m != 23'd0) ? 32'd0 : FULL_SCALE;
		end else if (e >= 8'd127) begin
			f32_mag = FULL_SCALE;
		end else if (e == 8'd0) begin
			f32_mag = 32'd0;
		end else if (e >= 8'd119) begin
			f32_mag = man << lsh[2:0];
		end else if (rsh >= 8'd32) begin
			f32_mag = 32'd0;
		end else begin
			f32_mag = man >> rsh[4:0];
		end
	end

	// Select by format; absolute values of the integer formats
	always_comb begin
		logic [15:0] v16;
		logic [7:0]  v8;
		v16        = sample_bits[15:0];
		v8         = sample_bits[7:0];
		mag.fmt_ok = 1'b1;
		case (sample_format)
			FMT_F32: mag.mag = f32_mag;
			FMT_I16: mag.mag = {(v16[15] ? 16'(16'd0 - v16) : v16), 16'd0};
			FMT_I32: mag.mag = sample_bits[31] ? 32'(32'd0 - sample_bits) : sample_bits;
			FMT_U8:  mag.mag = {(v8[7] ? 8'(v8 - 8'd128) : 8'(8'd128 - v8)), 24'd0};
			default: begin
				mag.mag    = 32'd0;
				mag.fmt_ok = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: hdl/asd_track.sv
// Frame peak, loud-frame tracking and frame counter; builds the report.
// Depends on asd_pkg for action codes, status codes and the result struct.
`default_nettype none

module asd_track
	import asd_pkg::*;
#(
	parameter int W = 40
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        step,
	input  wire logic [1:0]  action,
	input  wire logic        last_in_frame,
	input  wire mag_t        mag,
	input  wire logic [31:0] threshold,
	output result_t          result
);

	localparam int XW = (W > OUT_CNT_BITS) ? W : OUT_CNT_BITS;
	localparam logic [OUT_CNT_BITS-1:0] OUT_MAX = '1;
	localparam logic [W-1:0] CNT_MAX = '1;

	logic [W-1:0] frame_count_q;
	logic [W-1:0] first_loud_q;
	logic [W-1:0] last_loud_q;
	logic         loud_seen_q;
	logic [31:0]  peak_q;
	logic         fmt_err_q;

	logic [31:0]  peak_new;
	logic         loud;
	logic         sample_en;
	logic         clear_en;

	function automatic logic [OUT_CNT_BITS-1:0] sat_out(input logic [W-1:0] v);
		logic [XW-1:0] ext;
		ext = XW'(v);
		return (ext > XW'(OUT_MAX)) ? OUT_MAX : ext[OUT_CNT_BITS-1:0];
	endfunction

	assign peak_new  = (mag.mag > peak_q) ? mag.mag : peak_q;
	assign loud      = peak_new > threshold;
	assign sample_en = step && (action_t'(action) == ACT_SAMPLE) && !fmt_err_q;
	assign clear_en  = step && ((action_t'(action) == ACT_REPORT) ||
		(action_t'(action) == ACT_ABORT));

	// Advance per sample; clear everything on report or abort
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= '0;
			first_loud_q  <= '0;
			last_loud_q   <= '0;
			loud_seen_q   <= 1'b0;
			peak_q        <= '0;
			fmt_err_q     <= 1'b0;
		end else if (clear_en) begin
			frame_count_q <= '0;
			first_loud_q  <= '0;
			last_loud_q   <= '0;
			loud_seen_q   <= 1'b0;
			peak_q        <= '0;
			fmt_err_q     <= 1'b0;
		end else if (sample_en) begin
			if (!mag.fmt_ok) begin
				fmt_err_q <= 1'b1;
			end else if (last_in_frame) begin
				if (loud) begin
					if (!loud_seen_q) begin
						first_loud_q <= frame_count_q;
						loud_seen_q  <= 1'b1;
					end
					last_loud_q <= frame_count_q;
				end
				if (frame_count_q != CNT_MAX) begin
					frame_count_q <= W'(frame_count_q + 1'b1);
				end
				peak_q <= '0;
			end else begin
				peak_q <= peak_new;
			end
		end
	end

	// Build the report from the current state
	always_comb begin
		logic [W-1:0] trail;
		trail           = (last_loud_q < frame_count_q) ?
			W'(frame_count_q - last_loud_q - 1'b1) : '0;
		result.total    = '0;
		result.leading  = '0;
		result.trailing = '0;
		if (fmt_err_q) begin
			result.status = ST_BADFMT;
		end else if (frame_count_q == '0) begin
			result.status = ST_EMPTY;
		end else if (!loud_seen_q) begin
			result.status  = ST_SILENT;
			result.total   = sat_out(frame_count_q);
			result.leading = sat_out(frame_count_q);
		end else begin
			result.status   = ST_CONTENT;
			result.total    = sat_out(frame_count_q);
			result.leading  = sat_out(first_loud_q);
			result.trailing = sat_out(trail);
		end
	end

endmodule

`default_nettype wire

// File: hdl/audio_silence_span_detector_unit.sv
// Audio silence span detector: input register, conversion and tracking, result register.
// A report transaction is held in the input register and then loaded into the result register,
// which raises m_tvalid; a full, stalled result register can keep the report waiting in between.
// Throughput: one transaction per cycle; only a report waiting on a full, stalled
// result register holds the input stage.
// Reset: arst_n clears all tracking state, threshold to 2147484 and format to float32.
// Depends on asd_pkg, asd_cfg, asd_mag and asd_track.
`default_nettype none

module audio_silence_span_detector_unit
	import asd_pkg::*;
#(
	parameter int FRAME_COUNT_BITS = 40
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// Input stream
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [31:0]  s_tdata,   // [31:0] sample_bits
	input  wire logic [1:0]   s_tuser,   // [1:0] action
	input  wire logic         s_tlast,   // last_in_frame
	// Result stream
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [127:0]      m_tdata,   // [1:0] status, [41:2] total_frames,
	                                     // [81:42] leading_silence_frames,
	                                     // [121:82] trailing_silence_frames, zero pad
	// Configuration
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic        valid_s1;
	logic [1:0]  action_s1;
	logic [31:0] bits_s1;
	logic        last_s1;

	logic        out_valid_q;
	result_t     out_data_q;

	logic [31:0] threshold;
	logic [2:0]  sample_format;
	mag_t        mag;
	result_t     result;
	logic        is_report;
	logic        advance;
	logic        load_out;

	asd_cfg u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.threshold     (threshold),
		.sample_format (sample_format)
	);

	asd_mag u_mag (
		.sample_bits   (bits_s1),
		.sample_format (sample_format),
		.mag           (mag)
	);

	asd_track #(
		.W (FRAME_COUNT_BITS)
	) u_track (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance),
		.action        (action_s1),
		.last_in_frame (last_s1),
		.mag           (mag),
		.threshold     (threshold),
		.result        (result)
	);

	// Stall only a report that would overwrite an untaken result
	assign is_report = action_t'(action_s1) == ACT_REPORT;
	assign advance   = valid_s1 && !(is_report && out_valid_q && !m_tready);
	assign load_out  = advance && is_report;
	assign s_tready  = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			action_s1 <= s_tuser;
			bits_s1   <= s_tdata;
			last_s1   <= s_tlast;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_data_q.trailing, out_data_q.leading,
		out_data_q.total, out_data_q.status};

endmodule

`default_nettype wire
